// ===== sv/dsa_pkg.sv =====
// Package for the decimal string add/subtract block.
// Item, result and job types, symbol codes and sizing constants; no dependencies.
package dsa_pkg;

  localparam int MAX_DIGITS_DEF = 32;
  localparam int LEN_W          = 6;

  localparam logic [3:0] SYM_MINUS = 4'd10;
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [4:0] RADIX     = 5'd10;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SUB   = 1'b1;
  localparam logic SEL_A    = 1'b0;
  localparam logic SEL_B    = 1'b1;

  typedef struct packed {
    logic       operation;
    logic       operand_select;
    logic [3:0] digit;
    logic       last_digit;
  } in_item_t;

  typedef struct packed {
    logic [3:0] symbol;
    logic       last_symbol;
    logic       overflow;
  } out_item_t;

  typedef struct packed {
    logic             op;
    logic [LEN_W-1:0] a_len;
    logic [LEN_W-1:0] b_len;
    logic             ovf;
  } job_t;

endpackage

// ===== sv/dsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsa_ram #(
  parameter int WIDTH  = 4,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/dsa_jobq.sv =====
// Two-entry job queue between the loader front and the arithmetic back.
// Depends on dsa_pkg for the job type.
module dsa_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  dsa_pkg::job_t din,
  input  logic          pop,
  output logic          empty,
  output dsa_pkg::job_t dout
);
  import dsa_pkg::*;

  job_t       mem_r [2];
  logic       head_r, head_nxt;
  logic       tail_r, tail_nxt;
  logic [1:0] cnt_r,  cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      tail_nxt = ~tail_r;
    end
    if (do_pop) begin
      head_nxt = ~head_r;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[tail_r] <= din;
    end
  end

endmodule

// ===== sv/dsa_front.sv =====
// Loader front: takes digit items, writes the operand RAMs, tracks lengths and
// overflow, and queues a job on the final digit of B. Depends on dsa_pkg.
module dsa_front #(
  parameter int MAX_DIGITS = dsa_pkg::MAX_DIGITS_DEF,
  parameter int OPA_W      = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  dsa_pkg::in_item_t in_item,
  output logic              a_we,
  output logic [OPA_W-1:0]  a_waddr,
  output logic              b_we,
  output logic [OPA_W-1:0]  b_waddr,
  output logic [3:0]        wdata,
  output logic              job_push,
  input  logic              job_full,
  output dsa_pkg::job_t     job,
  input  logic              release_ops
);
  import dsa_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DIGITS);

  logic [LEN_W-1:0] a_len_r, a_len_nxt;
  logic [LEN_W-1:0] b_len_r, b_len_nxt;
  logic             a_closed_r, a_closed_nxt;
  logic             ovf_r, ovf_nxt;
  logic             hold_r, hold_nxt;
  logic             accept;
  logic [LEN_W-1:0] a_base;
  logic             b_at_cap;

  assign full     = hold_r | job_full;
  assign accept   = push & ~full;
  assign wdata    = (in_item.digit > DIGIT_MAX) ? DIGIT_MAX : in_item.digit;
  assign a_base   = a_closed_r ? '0 : a_len_r;
  assign b_at_cap = (b_len_r >= MAX_LEN);
  assign a_waddr  = a_base[OPA_W-1:0];
  assign b_waddr  = b_len_r[OPA_W-1:0];

  always_comb begin
    a_len_nxt    = a_len_r;
    b_len_nxt    = b_len_r;
    a_closed_nxt = a_closed_r;
    ovf_nxt      = ovf_r;
    hold_nxt     = hold_r;
    a_we         = 1'b0;
    b_we         = 1'b0;
    job_push     = 1'b0;
    job.op       = in_item.operation;
    job.a_len    = a_len_r;
    job.b_len    = b_at_cap ? b_len_r : b_len_r + 1'b1;
    job.ovf      = ovf_r | b_at_cap;
    if (accept) begin
      if (in_item.operand_select == SEL_A) begin
        a_closed_nxt = in_item.last_digit;
        if (a_base < MAX_LEN) begin
          a_we      = 1'b1;
          a_len_nxt = a_base + 1'b1;
        end else begin
          a_len_nxt = a_base;
          ovf_nxt   = 1'b1;
        end
      end else begin
        if (!b_at_cap) begin
          b_we      = 1'b1;
          b_len_nxt = b_len_r + 1'b1;
        end else begin
          ovf_nxt   = 1'b1;
        end
        if (in_item.last_digit) begin
          job_push     = 1'b1;
          a_len_nxt    = '0;
          b_len_nxt    = '0;
          a_closed_nxt = 1'b0;
          ovf_nxt      = 1'b0;
          hold_nxt     = 1'b1;
        end
      end
    end
    if (release_ops) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_len_r    <= '0;
      b_len_r    <= '0;
      a_closed_r <= 1'b0;
      ovf_r      <= 1'b0;
      hold_r     <= 1'b0;
    end else begin
      a_len_r    <= a_len_nxt;
      b_len_r    <= b_len_nxt;
      a_closed_r <= a_closed_nxt;
      ovf_r      <= ovf_nxt;
      hold_r     <= hold_nxt;
    end
  end

endmodule

// ===== sv/dsa_back.sv =====
// Arithmetic back: one pass over the operand RAMs forms the sum, A-B and B-A,
// then the result RAM is read out most significant first into a result queue.
// Depends on dsa_pkg.
module dsa_back #(
  parameter int OPA_W      = 5,
  parameter int RES_W      = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_empty,
  output logic               job_pop,
  input  dsa_pkg::job_t      job,
  output logic               release_ops,
  output logic [OPA_W-1:0]   a_raddr,
  input  logic [3:0]         a_rdata,
  output logic [OPA_W-1:0]   b_raddr,
  input  logic [3:0]         b_rdata,
  output logic               r_we,
  output logic [RES_W-1:0]   r_waddr,
  output logic [7:0]         r_wdata,
  output logic [RES_W-1:0]   r_raddr,
  input  logic [7:0]         r_rdata,
  input  logic               pop,
  output logic               empty,
  output dsa_pkg::out_item_t out_item
);
  import dsa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_t;

  localparam logic [2:0] Q_DEPTH = 3'd4;

  back_state_t      state_r, state_nxt;
  job_t             job_r, job_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] iss_r, iss_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [LEN_W-1:0] rd_i_r, rd_i_nxt;
  logic             rd_ain_r, rd_ain_nxt;
  logic             rd_bin_r, rd_bin_nxt;
  logic             carry_r, carry_nxt;
  logic             bab_r, bab_nxt;
  logic             bba_r, bba_nxt;
  logic [LEN_W-1:0] nzl_r, nzl_nxt;
  logic [LEN_W-1:0] nzh_r, nzh_nxt;
  logic [LEN_W-1:0] ptr_r, ptr_nxt;
  logic             neg_r, neg_nxt;
  logic             minus_r, minus_nxt;
  logic             infl_r, infl_nxt;
  logic             infl_hi_r, infl_hi_nxt;
  logic             infl_ovf_r, infl_ovf_nxt;
  logic             infl_last_r, infl_last_nxt;

  out_item_t        q_mem_r [4];
  logic [1:0]       q_head_r, q_tail_r;
  logic [2:0]       q_cnt_r;
  logic             q_push, q_pop;
  out_item_t        q_din;

  logic [3:0]       a_d, b_d;
  logic [4:0]       sum, yab, yba;
  logic             s_ge, ab_lt, ba_lt;
  logic [4:0]       s_dig, ab_dig, ba_dig;
  logic             credit;
  logic             minus_push;
  logic [LEN_W-1:0] a_idx, b_idx;

  assign a_d    = rd_ain_r ? a_rdata : 4'd0;
  assign b_d    = rd_bin_r ? b_rdata : 4'd0;
  assign sum    = {1'b0, a_d} + {1'b0, b_d} + {4'd0, carry_r};
  assign s_ge   = (sum >= RADIX);
  assign s_dig  = s_ge ? sum - RADIX : sum;
  assign yab    = {1'b0, b_d} + {4'd0, bab_r};
  assign ab_lt  = ({1'b0, a_d} < yab);
  assign ab_dig = ab_lt ? {1'b0, a_d} + RADIX - yab : {1'b0, a_d} - yab;
  assign yba    = {1'b0, a_d} + {4'd0, bba_r};
  assign ba_lt  = ({1'b0, b_d} < yba);
  assign ba_dig = ba_lt ? {1'b0, b_d} + RADIX - yba : {1'b0, b_d} - yba;

  assign a_idx   = job_r.a_len - 1'b1 - iss_r;
  assign b_idx   = job_r.b_len - 1'b1 - iss_r;
  assign a_raddr = a_idx[OPA_W-1:0];
  assign b_raddr = b_idx[OPA_W-1:0];

  assign r_raddr = ptr_r[RES_W-1:0];
  assign credit  = ((q_cnt_r + {2'd0, infl_r}) < Q_DEPTH);
  assign empty   = (q_cnt_r == 3'd0);
  assign q_pop   = pop & ~empty;
  assign out_item = q_mem_r[q_head_r];

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    n_nxt         = n_r;
    iss_nxt       = iss_r;
    rd_v_nxt      = 1'b0;
    rd_i_nxt      = rd_i_r;
    rd_ain_nxt    = rd_ain_r;
    rd_bin_nxt    = rd_bin_r;
    carry_nxt     = carry_r;
    bab_nxt       = bab_r;
    bba_nxt       = bba_r;
    nzl_nxt       = nzl_r;
    nzh_nxt       = nzh_r;
    ptr_nxt       = ptr_r;
    neg_nxt       = neg_r;
    minus_nxt     = minus_r;
    infl_nxt      = 1'b0;
    infl_hi_nxt   = infl_hi_r;
    infl_ovf_nxt  = infl_ovf_r;
    infl_last_nxt = infl_last_r;
    job_pop       = 1'b0;
    release_ops   = 1'b0;
    r_we          = 1'b0;
    r_waddr       = rd_i_r[RES_W-1:0];
    r_wdata       = (job_r.op == OP_SUB) ? {ba_dig[3:0], ab_dig[3:0]} : {4'd0, s_dig[3:0]};
    minus_push    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          job_nxt   = job;
          n_nxt     = (job.a_len > job.b_len) ? job.a_len : job.b_len;
          iss_nxt   = '0;
          carry_nxt = 1'b0;
          bab_nxt   = 1'b0;
          bba_nxt   = 1'b0;
          nzl_nxt   = '0;
          nzh_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (iss_r < n_r) begin
          rd_v_nxt   = 1'b1;
          rd_i_nxt   = iss_r;
          rd_ain_nxt = (iss_r < job_r.a_len);
          rd_bin_nxt = (iss_r < job_r.b_len);
          iss_nxt    = iss_r + 1'b1;
        end
        if (rd_v_r) begin
          r_we      = 1'b1;
          carry_nxt = s_ge;
          bab_nxt   = ab_lt;
          bba_nxt   = ba_lt;
          if (((job_r.op == OP_SUB) ? ab_dig[3:0] : s_dig[3:0]) != 4'd0) begin
            nzl_nxt = rd_i_r;
          end
          if (ba_dig[3:0] != 4'd0) begin
            nzh_nxt = rd_i_r;
          end
          if (rd_i_r == n_r - 1'b1) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        release_ops = 1'b1;
        r_waddr     = n_r[RES_W-1:0];
        r_wdata     = {7'd0, carry_r};
        if (job_r.op == OP_ADD) begin
          r_we      = 1'b1;
          neg_nxt   = 1'b0;
          ptr_nxt   = carry_r ? n_r : nzl_r;
        end else begin
          neg_nxt   = bab_r;
          ptr_nxt   = bab_r ? nzh_r : nzl_r;
        end
        minus_nxt = (job_r.op == OP_SUB) & bab_r;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (credit) begin
          if (minus_r) begin
            minus_push = 1'b1;
            minus_nxt  = 1'b0;
          end else begin
            infl_nxt      = 1'b1;
            infl_hi_nxt   = neg_r;
            infl_ovf_nxt  = job_r.ovf;
            infl_last_nxt = (ptr_r == '0);
            if (ptr_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              ptr_nxt = ptr_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_push = infl_r | minus_push;
    if (infl_r) begin
      q_din.symbol      = infl_hi_r ? r_rdata[7:4] : r_rdata[3:0];
      q_din.last_symbol = infl_last_r;
      q_din.overflow    = infl_ovf_r;
    end else begin
      q_din.symbol      = SYM_MINUS;
      q_din.last_symbol = 1'b0;
      q_din.overflow    = job_r.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_v_r   <= 1'b0;
      minus_r  <= 1'b0;
      infl_r   <= 1'b0;
      q_head_r <= 2'd0;
      q_tail_r <= 2'd0;
      q_cnt_r  <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= rd_v_nxt;
      minus_r  <= minus_nxt;
      infl_r   <= infl_nxt;
      if (q_push) begin
        q_tail_r <= q_tail_r + 2'd1;
      end
      if (q_pop) begin
        q_head_r <= q_head_r + 2'd1;
      end
      if (q_push && !q_pop) begin
        q_cnt_r <= q_cnt_r + 3'd1;
      end else if (q_pop && !q_push) begin
        q_cnt_r <= q_cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r         <= job_nxt;
    n_r           <= n_nxt;
    iss_r         <= iss_nxt;
    rd_i_r        <= rd_i_nxt;
    rd_ain_r      <= rd_ain_nxt;
    rd_bin_r      <= rd_bin_nxt;
    carry_r       <= carry_nxt;
    bab_r         <= bab_nxt;
    bba_r         <= bba_nxt;
    nzl_r         <= nzl_nxt;
    nzh_r         <= nzh_nxt;
    ptr_r         <= ptr_nxt;
    neg_r         <= neg_nxt;
    infl_hi_r     <= infl_hi_nxt;
    infl_ovf_r    <= infl_ovf_nxt;
    infl_last_r   <= infl_last_nxt;
    if (q_push) begin
      q_mem_r[q_tail_r] <= q_din;
    end
  end

endmodule

// ===== sv/decimal_string_add_subtract.sv =====
// Top level of the decimal string adder/subtractor.
// Depends on dsa_pkg, dsa_ram, dsa_jobq, dsa_front and dsa_back.
//
//   channel  handshake      payload      direction
//   input    push / full    in_item      in: one digit of A or B
//   result   pop / empty    out_item     out: one result symbol
//
// A digit item is taken when push is high and full is low. B's final digit
// queues a job; the back picks it up, walks max(len A, len B) digit positions
// at one per cycle through the registered operand RAM read ports, wraps up,
// then sends one symbol per cycle from the result RAM while the result queue
// has room. full stays high after the final B digit until the back has finished
// that walk. Reset is synchronous, active low; no memory clearing.
module decimal_string_add_subtract #(
  parameter int MAX_DIGITS = dsa_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  dsa_pkg::in_item_t  in_item,
  input  logic               pop,
  output logic               empty,
  output dsa_pkg::out_item_t out_item
);
  import dsa_pkg::*;

  localparam int OPA_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int RES_W = $clog2(MAX_DIGITS + 1);

  logic             a_we, b_we;
  logic [OPA_W-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [3:0]       wdata, a_rdata, b_rdata;
  logic             r_we;
  logic [RES_W-1:0] r_waddr, r_raddr;
  logic [7:0]       r_wdata, r_rdata;
  logic             job_push, job_full, job_pop, job_empty;
  job_t             job_in, job_out;
  logic             release_ops;

  dsa_front #(
    .MAX_DIGITS (MAX_DIGITS),
    .OPA_W      (OPA_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .a_we        (a_we),
    .a_waddr     (a_waddr),
    .b_we        (b_we),
    .b_waddr     (b_waddr),
    .wdata       (wdata),
    .job_push    (job_push),
    .job_full    (job_full),
    .job         (job_in),
    .release_ops (release_ops)
  );

  dsa_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .full  (job_full),
    .din   (job_in),
    .pop   (job_pop),
    .empty (job_empty),
    .dout  (job_out)
  );

  dsa_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS), .ADDR_W(OPA_W)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  dsa_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS), .ADDR_W(OPA_W)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  dsa_ram #(.WIDTH(8), .DEPTH(MAX_DIGITS + 1), .ADDR_W(RES_W)) u_ram_res (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  dsa_back #(
    .OPA_W      (OPA_W),
    .RES_W      (RES_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .job         (job_out),
    .release_ops (release_ops),
    .a_raddr     (a_raddr),
    .a_rdata     (a_rdata),
    .b_raddr     (b_raddr),
    .b_rdata     (b_rdata),
    .r_we        (r_we),
    .r_waddr     (r_waddr),
    .r_wdata     (r_wdata),
    .r_raddr     (r_raddr),
    .r_rdata     (r_rdata),
    .pop         (pop),
    .empty       (empty),
    .out_item    (out_item)
  );

endmodule

// ===== tb/sv/tb_decimal_string_add_subtract.sv =====
// Self-checking testbench for decimal_string_add_subtract: digit items in, result symbols out.
// Depends on dsa_pkg and the block. A typed directed table runs first, then random operand
// pairs with random push and pop stalls; untyped runs are checked by a cycle-free predictor.
module tb_decimal_string_add_subtract;
  timeunit 1ns;
  timeprecision 1ps;
  import dsa_pkg::*;

  localparam int MAXD      = MAX_DIGITS_DEF;
  localparam int ITEM_GOAL = 420;
  localparam int LIMIT     = 1_000_000;
  localparam int N_ROWS    = 24;

  typedef struct packed {
    logic            op;
    logic            sel;
    logic [3:0]      digit;
    logic            last;
    logic [1:0]      exp_n;
    logic [1:0][3:0] exp_sym;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       push;
  logic       full;
  in_item_t   in_item;
  logic       pop;
  logic       empty;
  out_item_t  out_item;

  logic [3:0] a_dig [0:MAXD-1];
  logic [3:0] b_dig [0:MAXD-1];
  int         a_len = 0;
  int         b_len = 0;
  bit         a_closed = 1'b0;
  bit         cap_hit = 1'b0;

  out_item_t  staged[$];
  out_item_t  expected_symbols[$];
  step_row_t  directed_steps [0:N_ROWS-1];

  int          fault_count = 0;
  int          items_sent = 0;
  int          run_count = 0;
  int          sub_runs = 0;
  int          ovf_runs = 0;
  int          symbols_checked = 0;
  int unsigned cycle_count = 0;
  bit          in_steady = 1'b0;
  bit          out_steady = 1'b0;

  decimal_string_add_subtract dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAIL decimal_string_add_subtract");
      $finish;
    end
  end

  function automatic step_row_t step_row(logic op, logic sel, logic [3:0] d, logic last,
                                         logic [1:0] n, logic [3:0] s0, logic [3:0] s1);
    step_row_t r;
    r.op = op;
    r.sel = sel;
    r.digit = d;
    r.last = last;
    r.exp_n = n;
    r.exp_sym[0] = s0;
    r.exp_sym[1] = s1;
    return r;
  endfunction

  function automatic int draw_wait(bit steady);
    return steady ? 0 : int'($urandom_range(0, 12));
  endfunction

  function automatic int place(bit from_b, int i);
    int n;
    n = from_b ? b_len : a_len;
    if (i >= n) return 0;
    return from_b ? int'(b_dig[n-1-i]) : int'(a_dig[n-1-i]);
  endfunction

  function automatic int sig_len(bit from_b);
    int n;
    int k;
    n = from_b ? b_len : a_len;
    k = 0;
    while (k < n && (from_b ? b_dig[k] : a_dig[k]) == 4'd0) k++;
    return n - k;
  endfunction

  task automatic apply_digit(input in_item_t it);
    logic [3:0] d;
    logic [3:0] res [0:MAXD];
    out_item_t  sym;
    int         n, cnt, i, acc, carry, x, y, ea, eb;
    bit         a_ge, neg;
    d = (it.digit > DIGIT_MAX) ? DIGIT_MAX : it.digit;
    if (it.operand_select == SEL_A) begin
      if (a_closed) begin
        a_len = 0;
        a_closed = 1'b0;
      end
      if (a_len < MAXD) begin
        a_dig[a_len] = d;
        a_len++;
      end else begin
        cap_hit = 1'b1;
      end
      if (it.last_digit) a_closed = 1'b1;
      return;
    end
    if (b_len < MAXD) begin
      b_dig[b_len] = d;
      b_len++;
    end else begin
      cap_hit = 1'b1;
    end
    if (!it.last_digit) return;
    n = (a_len > b_len) ? a_len : b_len;
    neg = 1'b0;
    carry = 0;
    if (it.operation == OP_ADD) begin
      for (i = 0; i < n; i++) begin
        acc = place(1'b0, i) + place(1'b1, i) + carry;
        res[i] = 4'(acc % 10);
        carry = acc / 10;
      end
      res[n] = 4'(carry);
      cnt = n + 1;
    end else begin
      ea = sig_len(1'b0);
      eb = sig_len(1'b1);
      a_ge = 1'b1;
      if (ea != eb) begin
        a_ge = (ea > eb);
      end else begin
        for (i = ea - 1; i >= 0; i--) begin
          x = place(1'b0, i);
          y = place(1'b1, i);
          if (x != y) begin
            a_ge = (x > y);
            break;
          end
        end
      end
      neg = !a_ge;
      for (i = 0; i < n; i++) begin
        x = place(neg, i);
        y = place(!neg, i) + carry;
        if (x < y) begin
          res[i] = 4'(x + 10 - y);
          carry = 1;
        end else begin
          res[i] = 4'(x - y);
          carry = 0;
        end
      end
      cnt = n;
      sub_runs++;
    end
    if (cnt == 0) begin
      res[0] = 4'd0;
      cnt = 1;
    end
    while (cnt > 1 && res[cnt-1] == 4'd0) cnt--;
    if (neg) begin
      sym.symbol = SYM_MINUS;
      sym.last_symbol = 1'b0;
      sym.overflow = cap_hit;
      staged.push_back(sym);
    end
    for (i = cnt - 1; i >= 0; i--) begin
      sym.symbol = res[i];
      sym.last_symbol = (i == 0);
      sym.overflow = cap_hit;
      staged.push_back(sym);
    end
    run_count++;
    if (cap_hit) ovf_runs++;
    a_len = 0;
    b_len = 0;
    cap_hit = 1'b0;
    a_closed = 1'b0;
  endtask

  task automatic send_item(input in_item_t it, input logic [1:0] typed_n,
                           input logic [1:0][3:0] typed_sym);
    int        gap;
    int        k;
    out_item_t sym;
    if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
    gap = draw_wait(in_steady);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    apply_digit(it);
    if (typed_n == 2'd0) begin
      foreach (staged[k]) expected_symbols.push_back(staged[k]);
    end else begin
      for (k = 0; k < int'(typed_n); k++) begin
        sym.symbol = typed_sym[k];
        sym.last_symbol = (k == int'(typed_n) - 1);
        sym.overflow = 1'b0;
        expected_symbols.push_back(sym);
      end
    end
    staged.delete();
  endtask

  function automatic logic [3:0] pick_digit(bit lead, int fill);
    int r;
    if (fill >= 0) return 4'(fill);
    r = $urandom_range(0, 99);
    if (r < 6) return 4'($urandom_range(10, 15));
    if (lead && r < 85) return 4'($urandom_range(1, 9));
    return 4'($urandom_range(0, 9));
  endfunction

  function automatic int draw_len(bit allow_zero);
    int r;
    r = $urandom_range(0, 99);
    if (allow_zero && r < 8) return 0;
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 20);
    if (r < 97) return $urandom_range(21, MAXD);
    return $urandom_range(MAXD + 1, MAXD + 3);
  endfunction

  task automatic send_pair(input int a_n, input int b_n, input int fill, input int op_choice);
    in_item_t it;
    int       i;
    bit       drop_a_last;
    drop_a_last = ($urandom_range(0, 9) == 0);
    for (i = 0; i < a_n; i++) begin
      it.operation = 1'($urandom_range(0, 1));
      it.operand_select = SEL_A;
      it.digit = pick_digit(i == 0, fill);
      it.last_digit = (i == a_n - 1) && !drop_a_last;
      send_item(it, 2'd0, '0);
    end
    for (i = 0; i < b_n; i++) begin
      it.operation = 1'($urandom_range(0, 1));
      if (i == b_n - 1 && op_choice == 0) it.operation = OP_ADD;
      if (i == b_n - 1 && op_choice == 1) it.operation = OP_SUB;
      it.operand_select = SEL_B;
      it.digit = pick_digit(i == 0, fill);
      it.last_digit = (i == b_n - 1);
      send_item(it, 2'd0, '0);
    end
  endtask

  initial begin
    out_item_t want;
    int        gap;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
      gap = draw_wait(out_steady);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (expected_symbols.size() == 0) begin
        fault_count++;
        $error("unexpected symbol %0d with nothing pending", out_item.symbol);
      end else begin
        want = expected_symbols.pop_front();
        symbols_checked++;
        if (out_item.symbol !== want.symbol) begin
          fault_count++;
          $error("symbol: expected %0d, got %0d", want.symbol, out_item.symbol);
        end
        if (out_item.last_symbol !== want.last_symbol) begin
          fault_count++;
          $error("last_symbol: expected %0d, got %0d", want.last_symbol, out_item.last_symbol);
        end
        if (out_item.overflow !== want.overflow) begin
          fault_count++;
          $error("overflow: expected %0d, got %0d", want.overflow, out_item.overflow);
        end
      end
    end
  end

  initial begin
    in_item_t it;
    int       i;
    int       k;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_item <= '0;
    directed_steps = '{
      step_row(OP_ADD, SEL_A, 4'd9,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_B, 4'd1,  1'b1, 2'd2, 4'd1, 4'd0),
      step_row(OP_ADD, SEL_A, 4'd3,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_SUB, SEL_B, 4'd5,  1'b1, 2'd2, SYM_MINUS, 4'd2),
      step_row(OP_ADD, SEL_A, 4'd0,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_SUB, SEL_B, 4'd0,  1'b1, 2'd1, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_B, 4'd15, 1'b1, 2'd1, 4'd9, 4'd0),
      step_row(OP_ADD, SEL_A, 4'd0,  1'b0, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_A, 4'd7,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_B, 4'd1,  1'b0, 2'd0, 4'd0, 4'd0),
      step_row(OP_SUB, SEL_B, 4'd2,  1'b1, 2'd2, SYM_MINUS, 4'd5),
      step_row(OP_ADD, SEL_A, 4'd5,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_A, 4'd8,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_SUB, SEL_B, 4'd8,  1'b1, 2'd1, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_A, 4'd1,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_B, 4'd0,  1'b0, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_B, 4'd1,  1'b1, 2'd1, 4'd2, 4'd0),
      step_row(OP_SUB, SEL_A, 4'd15, 1'b0, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_A, 4'd9,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_B, 4'd9,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_A, 4'd0,  1'b1, 2'd0, 4'd0, 4'd0),
      step_row(OP_SUB, SEL_B, 4'd0,  1'b0, 2'd0, 4'd0, 4'd0),
      step_row(OP_ADD, SEL_B, 4'd0,  1'b1, 2'd1, 4'd0, 4'd0),
      step_row(OP_SUB, SEL_B, 4'd10, 1'b1, 2'd2, SYM_MINUS, 4'd9)
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++) begin
      it.operation = directed_steps[i].op;
      it.operand_select = directed_steps[i].sel;
      it.digit = directed_steps[i].digit;
      it.last_digit = directed_steps[i].last;
      send_item(it, directed_steps[i].exp_n, directed_steps[i].exp_sym);
    end

    send_pair(MAXD + 1, MAXD, 9, 0);
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 99) < 12) begin
        for (k = $urandom_range(1, 4); k > 0; k--) begin
          it = in_item_t'(7'($urandom));
          send_item(it, 2'd0, '0);
        end
      end else begin
        send_pair(draw_len(1'b1), draw_len(1'b0), -1, 2);
      end
    end
    push <= 1'b0;

    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d digit items; checked %0d symbols in %0d result runs", items_sent,
             symbols_checked, run_count);
    $display("Runs: %0d subtract, %0d with dropped digits", sub_runs, ovf_runs);
    if (fault_count == 0 && expected_symbols.size() == 0) begin
      $display("PASS decimal_string_add_subtract");
    end else begin
      $display("FAIL decimal_string_add_subtract");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dsa_pkg.sv
sv/dsa_ram.sv
sv/dsa_jobq.sv
sv/dsa_front.sv
sv/dsa_back.sv
sv/decimal_string_add_subtract.sv
tb/sv/tb_decimal_string_add_subtract.sv
